// ----- rtl/core/spc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// spc_pkg: shared constants and helpers
// Formats, CORDIC angle table and output saturation for the converter.
// ----------------------------------------------------------------------------
package spc_pkg;

  localparam int RADIUS_BITS  = 16;
  localparam int ANGLE_BITS   = 16;
  localparam int CORDIC_STEPS = 24;
  localparam int XW           = 33;
  localparam int ZW           = 34;
  localparam int TRIG_W       = 22;
  localparam int PW           = RADIUS_BITS + TRIG_W;
  localparam int PRW          = PW - 20;
  localparam int RSW          = PW - 12;
  localparam int MW           = RSW + TRIG_W;
  localparam int SW           = MW - 28;
  localparam int DATA_W       = ((3 * RADIUS_BITS + 7) / 8) * 8;
  localparam int IN_W         = ((RADIUS_BITS + 2 * ANGLE_BITS + 7) / 8) * 8;
  localparam int LATENCY      = CORDIC_STEPS + 6;

  localparam logic [XW-1:0] CORDIC_GAIN = XW'(652032874);

  localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef logic signed [TRIG_W-1:0] trig_t;

  function automatic logic [RADIUS_BITS-1:0] sat_out(input logic [SW-1:0] v);
    logic [RADIUS_BITS-1:0] res;
    if ((&v[SW-1:RADIUS_BITS-1]) || !(|v[SW-1:RADIUS_BITS-1])) begin
      res = v[RADIUS_BITS-1:0];
    end else if (v[SW-1]) begin
      res = {1'b1, {(RADIUS_BITS-1){1'b0}}};
    end else begin
      res = {1'b0, {(RADIUS_BITS-1){1'b1}}};
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/spc_cordic.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// spc_cordic: pipelined rotation CORDIC
// One register stage per rotation; returns rounded cosine and sine.
// ----------------------------------------------------------------------------
module spc_cordic (
  input  wire logic                            clk,
  input  wire logic                            en,
  input  wire logic [spc_pkg::ANGLE_BITS-1:0]  ang,
  output spc_pkg::trig_t                       cos_val,
  output spc_pkg::trig_t                       sin_val
);
  import spc_pkg::*;

  logic signed [XW-1:0] xs   [CORDIC_STEPS+1];
  logic signed [XW-1:0] ys   [CORDIC_STEPS+1];
  logic signed [ZW-1:0] zs   [CORDIC_STEPS+1];
  logic                 flip [CORDIC_STEPS+1];

  logic [31:0] u;
  logic [31:0] u_add;
  logic        flip_in;
  logic [31:0] u_res;

  assign u       = 32'(ang) << (32 - ANGLE_BITS);
  assign u_add   = u + 32'h40000000;
  assign flip_in = u_add[31];
  assign u_res   = flip_in ? (u ^ 32'h80000000) : u;

  always_ff @(posedge clk) begin
    if (en) begin
      xs[0]   <= CORDIC_GAIN;
      ys[0]   <= '0;
      zs[0]   <= {{(ZW-32){u_res[31]}}, u_res};
      flip[0] <= flip_in;
    end
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
    logic signed [XW-1:0] xsh;
    logic signed [XW-1:0] ysh;
    logic                 pos;
    assign xsh = xs[k] >>> k;
    assign ysh = ys[k] >>> k;
    assign pos = !zs[k][ZW-1];
    always_ff @(posedge clk) begin
      if (en) begin
        xs[k+1]   <= pos ? xs[k] - ysh : xs[k] + ysh;
        ys[k+1]   <= pos ? ys[k] + xsh : ys[k] - xsh;
        zs[k+1]   <= pos ? zs[k] - ZW'(ATAN_TURNS[k]) : zs[k] + ZW'(ATAN_TURNS[k]);
        flip[k+1] <= flip[k];
      end
    end
  end

  logic signed [XW-1:0] xf;
  logic signed [XW-1:0] yf;
  logic        [XW:0]   xr;
  logic        [XW:0]   yr;

  assign xf = flip[CORDIC_STEPS] ? -xs[CORDIC_STEPS] : xs[CORDIC_STEPS];
  assign yf = flip[CORDIC_STEPS] ? -ys[CORDIC_STEPS] : ys[CORDIC_STEPS];
  assign xr = {xf[XW-1], xf} + (XW+1)'(512);
  assign yr = {yf[XW-1], yf} + (XW+1)'(512);

  always_ff @(posedge clk) begin
    if (en) begin
      cos_val <= xr[TRIG_W+9:10];
      sin_val <= yr[TRIG_W+9:10];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/spc_scale.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// spc_scale: radius scaling and output rounding
// Four register stages of products, rounding and saturation.
// ----------------------------------------------------------------------------
module spc_scale (
  input  wire logic                             clk,
  input  wire logic                             en,
  input  wire logic                             func,
  input  wire logic [spc_pkg::RADIUS_BITS-1:0]  radius,
  input  spc_pkg::trig_t                        cp,
  input  spc_pkg::trig_t                        sp,
  input  spc_pkg::trig_t                        ct,
  input  spc_pkg::trig_t                        st,
  output logic [spc_pkg::RADIUS_BITS-1:0]       x_coord,
  output logic [spc_pkg::RADIUS_BITS-1:0]       y_coord,
  output logic [spc_pkg::RADIUS_BITS-1:0]       z_coord
);
  import spc_pkg::*;

  logic signed [RADIUS_BITS-1:0] r_s;
  assign r_s = radius;

  // Stage A: radius products.
  logic signed [PW-1:0] a_pc, a_ps, a_pct, a_pst;
  trig_t                a_cp, a_sp;
  logic                 a_func;

  always_ff @(posedge clk) begin
    if (en) begin
      a_pc   <= r_s * cp;
      a_ps   <= r_s * sp;
      a_pct  <= r_s * ct;
      a_pst  <= r_s * st;
      a_cp   <= cp;
      a_sp   <= sp;
      a_func <= func;
    end
  end

  // Stage B: rounding of the first products.
  logic [PW-1:0] rx, ry, rz, rs_sum;
  assign rx     = a_pc  + PW'(1 << 19);
  assign ry     = a_ps  + PW'(1 << 19);
  assign rz     = a_pct + PW'(1 << 19);
  assign rs_sum = a_pst + PW'(1 << 11);

  logic [PRW-1:0]        b_px, b_py, b_pz;
  logic signed [RSW-1:0] b_rs;
  trig_t                 b_cp, b_sp;
  logic                  b_func;

  always_ff @(posedge clk) begin
    if (en) begin
      b_px   <= rx[PW-1:20];
      b_py   <= ry[PW-1:20];
      b_pz   <= rz[PW-1:20];
      b_rs   <= rs_sum[PW-1:12];
      b_cp   <= a_cp;
      b_sp   <= a_sp;
      b_func <= a_func;
    end
  end

  // Stage C: spherical products.
  logic signed [MW-1:0] c_mx, c_my;
  logic [PRW-1:0]       c_px, c_py, c_pz;
  logic                 c_func;

  always_ff @(posedge clk) begin
    if (en) begin
      c_mx   <= b_rs * b_cp;
      c_my   <= b_rs * b_sp;
      c_px   <= b_px;
      c_py   <= b_py;
      c_pz   <= b_pz;
      c_func <= b_func;
    end
  end

  // Stage D: final rounding, mode select and saturation.
  logic [MW-1:0] mxr, myr;
  logic [SW-1:0] sx, sy, sz;
  assign mxr = c_mx + MW'(1 << 27);
  assign myr = c_my + MW'(1 << 27);

  always_comb begin
    if (c_func) begin
      sx = mxr[MW-1:28];
      sy = myr[MW-1:28];
      sz = {{(SW-PRW){c_pz[PRW-1]}}, c_pz};
    end else begin
      sx = {{(SW-PRW){c_px[PRW-1]}}, c_px};
      sy = {{(SW-PRW){c_py[PRW-1]}}, c_py};
      sz = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_coord <= sat_out(sx);
      y_coord <= sat_out(sy);
      z_coord <= sat_out(sz);
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/spherical_polar_to_cartesian_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// spherical_polar_to_cartesian_core: polar and spherical to Cartesian
// Two CORDIC pipelines feed a multiply and round pipeline.
// ----------------------------------------------------------------------------
// Channel   Dir  tdata (low bit up)                       tuser
// s_axis    in   radius, polar_angle, azimuth             func
// m_axis    out  x_coord, y_coord, z_coord                -
//
// One transaction per cycle is accepted whenever the pipeline advances.
// The pipeline is made of the 24 CORDIC rotation stages plus prep, trig
// rounding and four scaling stages. The whole pipeline advances when the
// output register is empty or taken, so a stall loses nothing.
// Reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module spherical_polar_to_cartesian_core (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  // radius, polar_angle, azimuth
  input  wire logic [spc_pkg::IN_W-1:0]    s_axis_tdata,
  // func
  input  wire logic                        s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  // x_coord, y_coord, z_coord
  output logic [spc_pkg::DATA_W-1:0]       m_axis_tdata
);
  import spc_pkg::*;

  localparam int CW = CORDIC_STEPS + 2;

  logic en;
  logic [LATENCY-1:0] vld;

  assign en            = !vld[LATENCY-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[LATENCY-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LATENCY-2:0], s_axis_tvalid};
    end
  end

  logic [RADIUS_BITS-1:0] rad_in;
  logic [ANGLE_BITS-1:0]  theta_in, phi_in;
  assign rad_in   = s_axis_tdata[RADIUS_BITS-1:0];
  assign theta_in = s_axis_tdata[RADIUS_BITS +: ANGLE_BITS];
  assign phi_in   = s_axis_tdata[RADIUS_BITS+ANGLE_BITS +: ANGLE_BITS];

  logic [RADIUS_BITS-1:0] rad_d  [CW];
  logic                   func_d [CW];

  always_ff @(posedge clk) begin
    if (en) begin
      rad_d[0]  <= rad_in;
      func_d[0] <= s_axis_tuser;
      for (int i = 1; i < CW; i++) begin
        rad_d[i]  <= rad_d[i-1];
        func_d[i] <= func_d[i-1];
      end
    end
  end

  trig_t cp, sp, ct, st;

  spc_cordic u_phi (
    .clk     (clk),
    .en      (en),
    .ang     (phi_in),
    .cos_val (cp),
    .sin_val (sp)
  );

  spc_cordic u_theta (
    .clk     (clk),
    .en      (en),
    .ang     (theta_in),
    .cos_val (ct),
    .sin_val (st)
  );

  logic [RADIUS_BITS-1:0] x_c, y_c, z_c;

  spc_scale u_scale (
    .clk     (clk),
    .en      (en),
    .func    (func_d[CW-1]),
    .radius  (rad_d[CW-1]),
    .cp      (cp),
    .sp      (sp),
    .ct      (ct),
    .st      (st),
    .x_coord (x_c),
    .y_coord (y_c),
    .z_coord (z_c)
  );

  assign m_axis_tdata = DATA_W'({z_c, y_c, x_c});

endmodule
`default_nettype wire

// ----- rtl/core/spc_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// spc_checker: port-level checks for the converter core
// Watches the top-level ports for handshake and flow-control slips.
// ----------------------------------------------------------------------------
module spc_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       s_axis_tready,
  input wire logic                       m_axis_tvalid,
  input wire logic                       m_axis_tready,
  input wire logic [spc_pkg::DATA_W-1:0] m_axis_tdata
);
  import spc_pkg::*;

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("Stalled output transaction changed.");

  a_ready_flow: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("Input ready does not follow output flow control.");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("Output valid after reset.");

  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) && $past(s_axis_tready) |-> !$past(rst, LATENCY))
    else $error("Output transaction appeared too soon after reset.");

endmodule

bind spherical_polar_to_cartesian_core spc_checker u_spc_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

// ----- tb/sv/spherical_polar_to_cartesian_core_tb.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// spherical_polar_to_cartesian_core_tb: self-checking converter testbench
// Drives polar and spherical conversion requests over the input stream and
// compares each output transaction with a bit-accurate CORDIC predictor.
// Both stream sides idle at random; one long output stall fills the pipeline
// and one input pause lets the pipeline drain completely.
// ----------------------------------------------------------------------------
module spherical_polar_to_cartesian_core_tb;
  import spc_pkg::*;

  localparam int NUM_RANDOM = 1800;
  localparam int WATCHDOG   = 20000;

  typedef struct packed {
    logic                          func;
    logic signed [RADIUS_BITS-1:0] radius;
    logic [ANGLE_BITS-1:0]         polar_angle;
    logic [ANGLE_BITS-1:0]         azimuth;
  } req_t;

  typedef struct packed {
    logic signed [RADIUS_BITS-1:0] x_coord;
    logic signed [RADIUS_BITS-1:0] y_coord;
    logic signed [RADIUS_BITS-1:0] z_coord;
  } coord_t;

  typedef struct {
    req_t   req;
    logic   known;
    coord_t coord;
  } vec_t;

  logic               clk;
  logic               rst;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [IN_W-1:0]    s_axis_tdata;
  logic               s_axis_tuser;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [DATA_W-1:0]  m_axis_tdata;

  coord_t coord_queue[$];
  int     mismatches;
  int     n_results;
  int     n_spherical;
  int     n_saturated;
  int     idle_cycles;
  bit     hold_output;
  bit     stim_done;

  spherical_polar_to_cartesian_core u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint floor_shift(input longint v, input int s);
    return v >>> s;
  endfunction

  function automatic longint round_to(input longint v, input int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  // Returns cosine and sine with 20 fraction bits.
  task automatic cordic_trig(input logic [ANGLE_BITS-1:0] ang,
                             output longint c, output longint s);
    logic [31:0] turn;
    bit          flip;
    longint      z, x, y, nx;
    turn = {ang, {(32 - ANGLE_BITS){1'b0}}};
    flip = ((turn + 32'h4000_0000) & 32'h8000_0000) != 0;
    if (flip) turn = turn - 32'h8000_0000;
    z = longint'($signed(turn));
    x = 652032874;
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - floor_shift(y, i);
        y  = y + floor_shift(x, i);
        z  = z - longint'(ATAN_TURNS[i]);
      end else begin
        nx = x + floor_shift(y, i);
        y  = y - floor_shift(x, i);
        z  = z + longint'(ATAN_TURNS[i]);
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = round_to(x, 10);
    s = round_to(y, 10);
  endtask

  function automatic logic signed [RADIUS_BITS-1:0] clamp_coord(input longint v);
    longint hi, lo;
    hi = (longint'(1) << (RADIUS_BITS - 1)) - 1;
    lo = -(longint'(1) << (RADIUS_BITS - 1));
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[RADIUS_BITS-1:0];
  endfunction

  task automatic convert_coord(input req_t rq, output coord_t res);
    longint r, cp, sp, ct, st, rs;
    r = longint'(rq.radius);
    cordic_trig(rq.azimuth, cp, sp);
    if (!rq.func) begin
      res.x_coord = clamp_coord(round_to(r * cp, 20));
      res.y_coord = clamp_coord(round_to(r * sp, 20));
      res.z_coord = '0;
    end else begin
      cordic_trig(rq.polar_angle, ct, st);
      rs = round_to(r * st, 12);
      res.x_coord = clamp_coord(round_to(rs * cp, 28));
      res.y_coord = clamp_coord(round_to(rs * sp, 28));
      res.z_coord = clamp_coord(round_to(r * ct, 20));
    end
  endtask

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  task automatic send_request(input req_t rq, input logic has_exp, input coord_t exp_c);
    coord_t pred;
    int     gap;
    gap = gap_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= rq.func;
    s_axis_tdata  <= IN_W'({rq.azimuth, rq.polar_angle, rq.radius});
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    convert_coord(rq, pred);
    if (has_exp && pred !== exp_c) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Typed expectation disagrees with prediction: %p vs %p", exp_c, pred);
    end
    coord_queue.push_back(has_exp ? exp_c : pred);
    if (rq.func) n_spherical++;
    @(negedge clk);
  endtask

  function automatic req_t random_request();
    req_t rq;
    int   p;
    rq.func        = 1'($urandom_range(0, 1));
    rq.polar_angle = ANGLE_BITS'($urandom);
    rq.azimuth     = ANGLE_BITS'($urandom);
    p = $urandom_range(0, 9);
    if (p == 0) rq.radius = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
    else if (p == 1) rq.radius = $signed(16'($urandom_range(0, 15))) - 16'sd8;
    else rq.radius = RADIUS_BITS'($urandom);
    if ($urandom_range(0, 7) == 0) rq.azimuth = 16'($urandom_range(0, 7)) << 13;
    return rq;
  endfunction

  // Directed rows: zero radius, axis-aligned extremes and saturation corners.
  vec_t directed[$];

  task automatic add_row(input logic f, input int r, input int th, input int ph,
                         input logic k, input int x, input int y, input int z);
    vec_t v;
    v.req   = '{func: f, radius: r[15:0], polar_angle: th[15:0], azimuth: ph[15:0]};
    v.known = k;
    v.coord = '{x_coord: x[15:0], y_coord: y[15:0], z_coord: z[15:0]};
    directed.push_back(v);
  endtask

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    stim_done     = 1'b0;
    hold_output   = 1'b0;
    mismatches    = 0;
    n_results     = 0;
    n_spherical   = 0;
    n_saturated   = 0;
    add_row(0, 0, 0, 0, 1, 0, 0, 0);
    add_row(1, 0, 16'hFFFF, 16'hFFFF, 1, 0, 0, 0);
    add_row(0, 32767, 0, 0, 0, 0, 0, 0);
    add_row(0, -32768, 0, 0, 0, 0, 0, 0);
    add_row(0, 32767, 0, 16'h4000, 0, 0, 0, 0);
    add_row(0, -32768, 0, 16'h8000, 0, 0, 0, 0);
    add_row(0, -32768, 0, 16'hC000, 0, 0, 0, 0);
    add_row(0, 32767, 0, 16'h2000, 0, 0, 0, 0);
    add_row(0, 32767, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0);
    add_row(1, 32767, 0, 0, 0, 0, 0, 0);
    add_row(1, -32768, 16'h8000, 0, 0, 0, 0, 0);
    add_row(1, -32768, 16'h4000, 16'h8000, 0, 0, 0, 0);
    add_row(1, 32767, 16'h4000, 16'h4000, 0, 0, 0, 0);
    add_row(1, 32767, 16'hC000, 16'h6000, 0, 0, 0, 0);
    add_row(1, -1, 16'h2000, 16'hE000, 0, 0, 0, 0);
    add_row(1, 1, 16'h5555, 16'hAAAA, 0, 0, 0, 0);
    add_row(0, -1, 16'h1234, 16'h7FFF, 0, 0, 0, 0);
    add_row(1, 12345, 16'h7FFF, 16'h8001, 0, 0, 0, 0);
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    foreach (directed[i]) send_request(directed[i].req, directed[i].known, directed[i].coord);
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == 300) begin
        // Stall the output long enough to back the pipeline up to the input.
        hold_output = 1'b1;
        fork
          begin
            repeat (LATENCY * 3) @(posedge clk);
            hold_output = 1'b0;
          end
        join_none
      end
      if (i == 900) begin
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (coord_queue.size() != 0) @(negedge clk);
      end
      send_request(random_request(), 1'b0, '0);
    end
    s_axis_tvalid <= 1'b0;
    stim_done = 1'b1;
  end

  // Output side: random backpressure, plus the long hold requested above.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      int gap;
      @(negedge clk);
      gap = gap_len();
      if (hold_output || gap > 0) begin
        m_axis_tready <= 1'b0;
        if (!hold_output) repeat (gap - 1) @(negedge clk);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      coord_t got, exp_c;
      got.x_coord = m_axis_tdata[RADIUS_BITS-1:0];
      got.y_coord = m_axis_tdata[RADIUS_BITS +: RADIUS_BITS];
      got.z_coord = m_axis_tdata[2*RADIUS_BITS +: RADIUS_BITS];
      n_results++;
      if (coord_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected output transaction: %p", got);
      end else begin
        exp_c = coord_queue.pop_front();
        if (exp_c.x_coord == 16'sh7FFF || exp_c.x_coord == 16'sh8000) n_saturated++;
        if (got !== exp_c) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch x/y/z expected %0d %0d %0d got %0d %0d %0d",
                     exp_c.x_coord, exp_c.y_coord, exp_c.z_coord,
                     got.x_coord, got.y_coord, got.z_coord);
        end
      end
    end
  end

  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG) begin
        $display("Watchdog expired with %0d results outstanding", coord_queue.size());
        $display("DONE: errors detected");
        $finish;
      end
      if (stim_done && coord_queue.size() == 0) begin
        repeat (LATENCY + 10) @(posedge clk);
        if (coord_queue.size() != 0) mismatches++;
        $display("Checked %0d conversions, %0d spherical, %0d with x at a rail.",
                 n_results, n_spherical, n_saturated);
        if (mismatches == 0) begin
          $display("DONE: 0 errors");
        end else begin
          $display("DONE: errors detected");
        end
        $finish;
      end
    end
  end

endmodule
`default_nettype wire
